// ===== src/tcbe_pkg.sv =====
// types and codes shared by the triplet context bucket engine
// no dependencies

package tcbe_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned AW      = 10;
  localparam int unsigned LW      = 11;
  localparam int unsigned NPAT    = 8;

  localparam logic [2:0] REQ_LOAD      = 3'd0;
  localparam logic [2:0] REQ_FLIP_POS  = 3'd1;
  localparam logic [2:0] REQ_FLIP_RANK = 3'd2;
  localparam logic [2:0] REQ_COUNT     = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_BAD_RANK = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CNT      = 11'b000_0000_0010,
    S_PREFIX   = 11'b000_0000_0100,
    S_PUT      = 11'b000_0000_1000,
    S_CTX_RD   = 11'b000_0001_0000,
    S_POS_RD   = 11'b000_0010_0000,
    S_SW_A     = 11'b000_0100_0000,
    S_SW_B     = 11'b000_1000_0000,
    S_SW_C     = 11'b001_0000_0000,
    S_SLOT_FIN = 11'b010_0000_0000,
    S_NEXT     = 11'b100_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_MAIN  = 3'b001,
    PH_LEFT  = 3'b010,
    PH_RIGHT = 3'b100
  } phase_t;

endpackage

// ===== src/triplet_context_bucket_engine_top.sv =====
// triplet context bucket engine: bucketed permutation of interior positions
// depends on tcbe_pkg and tcbe_ram
//
// channel  ports                                   handshake
// in       in_req_type .. in_rank                  start, busy
// out      out_status .. out_read_bit              out_valid strobe
//
// load, count, error answers and end-bit reads come in the cycle after the request
// interior read: slot ram read, then S_CTX_RD, then registered result; flip:
// up to three bucket walks of two, one and four swaps, each swap stepping
// through S_SW_A, S_SW_B and S_SW_C; last load bit: build reads the bit ram twice
// reset is synchronous; the result strobe lasts one cycle and is never held

module triplet_context_bucket_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic       in_bit_value,
  input  logic       in_last,
  input  logic [9:0] in_position,
  input  logic [2:0] in_context_req,
  input  logic [9:0] in_rank,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [9:0] out_result_position,
  output logic [2:0] out_result_context,
  output logic [9:0] out_count,
  output logic       out_read_bit
);

  tcbe_pkg::state_t state_r, state_nxt;
  tcbe_pkg::phase_t phase_r, phase_nxt;

  logic [10:0] len_r, len_nxt;
  logic        built_r, built_nxt;
  logic        first_r, first_nxt;
  logic        final_r, final_nxt;
  logic [9:0]  bs_r [9];
  logic [9:0]  bs_nxt [9];
  logic [10:0] ia_r, ia_nxt;
  logic        rv_r, rv_nxt;
  logic [10:0] rj_r, rj_nxt;
  logic [1:0]  win_r, win_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [9:0]  p_r, p_nxt;
  logic [9:0]  m_r, m_nxt;
  logic [9:0]  prev_r, prev_nxt;
  logic [9:0]  cur_r, cur_nxt;
  logic [9:0]  pb_r, pb_nxt;
  logic [2:0]  c_r, c_nxt;
  logic [2:0]  to_r, to_nxt;
  logic        rdop_r, rdop_nxt;
  logic [2:0]  rctx_r, rctx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [9:0] out_pos_r, out_pos_nxt;
  logic [2:0] out_ctx_r, out_ctx_nxt;
  logic [9:0] out_cnt_r, out_cnt_nxt;
  logic       out_bit_r, out_bit_nxt;

  logic       bits_we;
  logic [9:0] bits_waddr, bits_raddr;
  logic [0:0] bits_wdata, bits_rd;
  logic       pos_we;
  logic [9:0] pos_waddr, pos_wdata, pos_raddr, pos_rd;
  logic       slot_we;
  logic [9:0] slot_waddr, slot_wdata, slot_raddr, slot_rd;

  logic       accept;
  logic [2:0] ctx_dec;
  logic [3:0] ctx_hi;
  logic [9:0] bsize;
  logic [9:0] rank_slot;

  tcbe_ram #(.WIDTH(1), .DEPTH(1024)) u_bits (
    .clk(clk), .we(bits_we), .waddr(bits_waddr), .wdata(bits_wdata),
    .raddr(bits_raddr), .rdata(bits_rd)
  );

  tcbe_ram #(.WIDTH(10), .DEPTH(1024)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rd)
  );

  tcbe_ram #(.WIDTH(10), .DEPTH(1024)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  assign busy   = (state_r != tcbe_pkg::S_IDLE);
  assign accept = start && !busy;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_position = out_pos_r;
  assign out_result_context  = out_ctx_r;
  assign out_count           = out_cnt_r;
  assign out_read_bit        = out_bit_r;

  // bucket of a slot, buckets kept in ascending order
  always_comb begin
    ctx_dec = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (bs_r[k] <= slot_rd) begin
        ctx_dec = 3'(k);
      end
    end
  end

  assign ctx_hi    = {1'b0, in_context_req} + 4'd1;
  assign bsize     = bs_r[ctx_hi] - bs_r[{1'b0, in_context_req}];
  assign rank_slot = bs_r[{1'b0, in_context_req}] + in_rank;

  always_comb begin
    logic [10:0] base;
    logic        kept;
    logic [10:0] newlen;
    logic [2:0]  pat;
    logic [9:0]  x;
    logic [9:0]  cur;

    state_nxt = state_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    built_nxt = built_r;
    first_nxt = first_r;
    final_nxt = final_r;
    bs_nxt    = bs_r;
    ia_nxt    = ia_r;
    rv_nxt    = rv_r;
    rj_nxt    = rj_r;
    win_nxt   = win_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    pb_nxt    = pb_r;
    c_nxt     = c_r;
    to_nxt    = to_r;
    rdop_nxt  = rdop_r;
    rctx_nxt  = rctx_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = tcbe_pkg::ST_OK;
    out_pos_nxt    = '0;
    out_ctx_nxt    = '0;
    out_cnt_nxt    = '0;
    out_bit_nxt    = 1'b0;

    bits_we    = 1'b0;
    bits_waddr = '0;
    bits_wdata = '0;
    bits_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;

    base   = built_r ? 11'd0 : len_r;
    kept   = (base < 11'(tcbe_pkg::MAX_LEN));
    newlen = base + {10'd0, kept};
    pat    = {win_r, bits_rd[0]};
    x      = bs_r[{1'b0, pat}] - 10'd1;
    cur    = '0;

    case (state_r)
      tcbe_pkg::S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            tcbe_pkg::REQ_LOAD: begin
              built_nxt = 1'b0;
              len_nxt   = newlen;
              if (kept) begin
                bits_we    = 1'b1;
                bits_waddr = base[9:0];
                bits_wdata = in_bit_value;
              end
              if (in_last && kept && newlen >= 11'd3) begin
                state_nxt = tcbe_pkg::S_CNT;
                for (int k = 0; k < 8; k++) begin
                  bs_nxt[k] = '0;
                end
                ia_nxt = '0;
                rv_nxt = 1'b0;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = (!kept || in_last) ? tcbe_pkg::ST_NOT_READY
                                                    : tcbe_pkg::ST_OK;
                if (in_last) begin
                  len_nxt = '0;
                end
              end
            end
            tcbe_pkg::REQ_FLIP_POS: begin
              if (!built_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_NOT_READY;
              end else if (in_position == 10'd0 ||
                           ({1'b0, in_position} + 11'd1) >= len_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_BAD_POS;
              end else begin
                slot_raddr = in_position;
                p_nxt      = in_position;
                m_nxt      = in_position;
                phase_nxt  = tcbe_pkg::PH_MAIN;
                rdop_nxt   = 1'b0;
                state_nxt  = tcbe_pkg::S_CTX_RD;
              end
            end
            tcbe_pkg::REQ_FLIP_RANK: begin
              if (!built_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_NOT_READY;
              end else if (in_rank >= bsize) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_BAD_RANK;
              end else begin
                pos_raddr = rank_slot;
                prev_nxt  = rank_slot;
                c_nxt     = in_context_req;
                to_nxt    = in_context_req ^ 3'd2;
                rctx_nxt  = in_context_req;
                phase_nxt = tcbe_pkg::PH_MAIN;
                rdop_nxt  = 1'b0;
                state_nxt = tcbe_pkg::S_POS_RD;
              end
            end
            tcbe_pkg::REQ_COUNT: begin
              out_valid_nxt = 1'b1;
              if (!built_r) begin
                out_status_nxt = tcbe_pkg::ST_NOT_READY;
              end else begin
                out_cnt_nxt = bsize;
              end
            end
            tcbe_pkg::REQ_READ: begin
              if (!built_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_NOT_READY;
              end else if ({1'b0, in_position} >= len_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tcbe_pkg::ST_BAD_POS;
              end else if (in_position == 10'd0) begin
                out_valid_nxt = 1'b1;
                out_bit_nxt   = first_r;
              end else if ({1'b0, in_position} == len_r - 11'd1) begin
                out_valid_nxt = 1'b1;
                out_bit_nxt   = final_r;
              end else begin
                slot_raddr = in_position;
                rdop_nxt   = 1'b1;
                state_nxt  = tcbe_pkg::S_CTX_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      tcbe_pkg::S_CNT, tcbe_pkg::S_PUT: begin
        if (ia_r < len_r) begin
          bits_raddr = ia_r[9:0];
          ia_nxt     = ia_r + 11'd1;
          rv_nxt     = 1'b1;
          rj_nxt     = ia_r;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          win_nxt = {win_r[0], bits_rd[0]};
          if (state_r == tcbe_pkg::S_CNT) begin
            if (rj_r >= 11'd2) begin
              bs_nxt[{1'b0, pat}] = bs_r[{1'b0, pat}] + 10'd1;
            end
            if (rj_r == len_r - 11'd1) begin
              k_nxt     = 3'd1;
              state_nxt = tcbe_pkg::S_PREFIX;
            end
          end else begin
            if (rj_r >= 11'd2) begin
              bs_nxt[{1'b0, pat}] = x;
              pos_we     = 1'b1;
              pos_waddr  = x;
              pos_wdata  = 10'(rj_r - 11'd1);
              slot_we    = 1'b1;
              slot_waddr = 10'(rj_r - 11'd1);
              slot_wdata = x;
            end
            if (rj_r == 11'd0) begin
              first_nxt = bits_rd[0];
            end
            if (rj_r == len_r - 11'd1) begin
              final_nxt     = bits_rd[0];
              bs_nxt[8]     = 10'(len_r - 11'd2);
              built_nxt     = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = tcbe_pkg::S_IDLE;
            end
          end
        end
      end

      tcbe_pkg::S_PREFIX: begin
        bs_nxt[{1'b0, k_r}] = bs_r[{1'b0, k_r}] + bs_r[{1'b0, k_r - 3'd1}];
        if (k_r == 3'd7) begin
          ia_nxt    = '0;
          rv_nxt    = 1'b0;
          state_nxt = tcbe_pkg::S_PUT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end

      tcbe_pkg::S_CTX_RD: begin
        if (rdop_r) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = ctx_dec[1];
          state_nxt     = tcbe_pkg::S_IDLE;
        end else begin
          prev_nxt  = slot_rd;
          c_nxt     = ctx_dec;
          state_nxt = tcbe_pkg::S_SW_A;
          case (phase_r)
            tcbe_pkg::PH_MAIN: begin
              to_nxt   = ctx_dec ^ 3'd2;
              rctx_nxt = ctx_dec;
            end
            tcbe_pkg::PH_LEFT: begin
              to_nxt = ctx_dec ^ 3'd1;
            end
            default: begin
              to_nxt = ctx_dec ^ 3'd4;
            end
          endcase
        end
      end

      tcbe_pkg::S_POS_RD: begin
        m_nxt     = pos_rd;
        p_nxt     = pos_rd;
        state_nxt = tcbe_pkg::S_SW_A;
      end

      tcbe_pkg::S_SW_A: begin
        if (c_r == to_r) begin
          state_nxt = tcbe_pkg::S_SLOT_FIN;
        end else begin
          if (c_r > to_r) begin
            cur                  = bs_r[{1'b0, c_r}];
            bs_nxt[{1'b0, c_r}]  = cur + 10'd1;
            c_nxt                = c_r - 3'd1;
          end else begin
            cur                           = bs_r[{1'b0, c_r} + 4'd1] - 10'd1;
            bs_nxt[{1'b0, c_r} + 4'd1]    = cur;
            c_nxt                         = c_r + 3'd1;
          end
          pos_raddr = cur;
          cur_nxt   = cur;
          state_nxt = tcbe_pkg::S_SW_B;
        end
      end

      tcbe_pkg::S_SW_B: begin
        pb_nxt     = pos_rd;
        pos_we     = 1'b1;
        pos_waddr  = cur_r;
        pos_wdata  = m_r;
        slot_we    = 1'b1;
        slot_waddr = pos_rd;
        slot_wdata = prev_r;
        state_nxt  = tcbe_pkg::S_SW_C;
      end

      tcbe_pkg::S_SW_C: begin
        pos_we    = 1'b1;
        pos_waddr = prev_r;
        pos_wdata = pb_r;
        prev_nxt  = cur_r;
        state_nxt = tcbe_pkg::S_SW_A;
      end

      tcbe_pkg::S_SLOT_FIN: begin
        slot_we    = 1'b1;
        slot_waddr = m_r;
        slot_wdata = prev_r;
        state_nxt  = tcbe_pkg::S_NEXT;
      end

      tcbe_pkg::S_NEXT: begin
        if (phase_r == tcbe_pkg::PH_MAIN && p_r >= 10'd2) begin
          phase_nxt  = tcbe_pkg::PH_LEFT;
          m_nxt      = p_r - 10'd1;
          slot_raddr = p_r - 10'd1;
          state_nxt  = tcbe_pkg::S_CTX_RD;
        end else if (phase_r != tcbe_pkg::PH_RIGHT &&
                     ({1'b0, p_r} + 11'd2) < len_r) begin
          phase_nxt  = tcbe_pkg::PH_RIGHT;
          m_nxt      = p_r + 10'd1;
          slot_raddr = p_r + 10'd1;
          state_nxt  = tcbe_pkg::S_CTX_RD;
        end else begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = p_r;
          out_ctx_nxt   = rctx_r;
          state_nxt     = tcbe_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tcbe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcbe_pkg::S_IDLE;
      phase_r     <= tcbe_pkg::PH_MAIN;
      len_r       <= '0;
      built_r     <= 1'b0;
      first_r     <= 1'b0;
      final_r     <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        bs_r[k] <= '0;
      end
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      built_r     <= built_nxt;
      first_r     <= first_nxt;
      final_r     <= final_nxt;
      bs_r        <= bs_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r         <= ia_nxt;
    rj_r         <= rj_nxt;
    win_r        <= win_nxt;
    k_r          <= k_nxt;
    p_r          <= p_nxt;
    m_r          <= m_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    pb_r         <= pb_nxt;
    c_r          <= c_nxt;
    to_r         <= to_nxt;
    rdop_r       <= rdop_nxt;
    rctx_r       <= rctx_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_ctx_r    <= out_ctx_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_bit_r    <= out_bit_nxt;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    (built_r && state_r == tcbe_pkg::S_IDLE) |-> (bs_r[8] == 10'(len_r - 11'd2)))
    else $error("bucket total does not match interior length");

  assert property (@(posedge clk) disable iff (!rst_n)
    (built_r && state_r == tcbe_pkg::S_IDLE) |->
      (bs_r[0] == 10'd0 && bs_r[0] <= bs_r[1] && bs_r[1] <= bs_r[2] &&
       bs_r[2] <= bs_r[3] && bs_r[3] <= bs_r[4] && bs_r[4] <= bs_r[5] &&
       bs_r[5] <= bs_r[6] && bs_r[6] <= bs_r[7] && bs_r[7] <= bs_r[8]))
    else $error("bucket boundaries out of order");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(start) || $past(busy)))
    else $error("result strobe without a request");
`endif

endmodule

// ===== src/tcbe_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module tcbe_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tcbe_checker.sv =====
`timescale 1ns / 1ps
// checker for the triplet context bucket engine: keeps its own copy of the sequence,
// the buckets and the permutation, predicts each answer and compares it
// depends on tcbe_pkg

module tcbe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic        in_bit_value,
  input  logic        in_last,
  input  logic [9:0]  in_position,
  input  logic [2:0]  in_context_req,
  input  logic [9:0]  in_rank,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [9:0]  out_result_position,
  input  logic [2:0]  out_result_context,
  input  logic [9:0]  out_count,
  input  logic        out_read_bit,
  output int          fail_count,
  output int          pending,
  output int          answers_seen,
  output int          flips_seen,
  output int          builds_seen
);

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] rpos;
    logic [2:0] rctx;
    logic [9:0] cnt;
    logic       rbit;
  } answer_t;

  answer_t answer_q[$];

  logic        seq_bits [tcbe_pkg::MAX_LEN];
  int unsigned bstart [tcbe_pkg::NPAT+1];
  int unsigned pos_at_slot [tcbe_pkg::MAX_LEN];
  int unsigned slot_of [tcbe_pkg::MAX_LEN];
  logic        end_lo, end_hi;
  int unsigned seq_len;
  logic        ready;

  assign pending = answer_q.size();

  function automatic int unsigned clip(int unsigned i);
    return (i < tcbe_pkg::MAX_LEN) ? i : 0;
  endfunction

  function automatic int unsigned nbr_pattern(int unsigned p);
    return {29'd0, seq_bits[clip(p - 1)], seq_bits[clip(p)], seq_bits[clip(p + 1)]};
  endfunction

  task automatic sort_buckets();
    int unsigned cum [tcbe_pkg::NPAT];
    int unsigned c, x;
    for (int k = 0; k < tcbe_pkg::NPAT; k++) cum[k] = 0;
    for (int unsigned i = 1; i + 1 < seq_len; i++) cum[nbr_pattern(i)]++;
    for (int k = 1; k < tcbe_pkg::NPAT; k++) cum[k] += cum[k-1];
    for (int unsigned i = 1; i + 1 < seq_len; i++) begin
      c = nbr_pattern(i);
      cum[c]--;
      x = clip(cum[c]);
      pos_at_slot[x] = i;
      slot_of[i] = x;
    end
    for (int k = 0; k < tcbe_pkg::NPAT; k++) bstart[k] = cum[k];
    bstart[tcbe_pkg::NPAT] = seq_len - 2;
    end_lo = seq_bits[0];
    end_hi = seq_bits[clip(seq_len - 1)];
    ready = 1'b1;
  endtask

  function automatic int unsigned bucket_of(int unsigned p);
    int unsigned idx, pat;
    idx = slot_of[clip(p)];
    pat = 0;
    while (pat < 7 && bstart[pat+1] <= idx) pat++;
    return pat;
  endfunction

  task automatic swap_slots(int unsigned a, int unsigned b);
    int unsigned sa, sb, pa, pb, t;
    sa = clip(a);
    sb = clip(b);
    pa = clip(pos_at_slot[sa]);
    pb = clip(pos_at_slot[sb]);
    t = slot_of[pa];
    slot_of[pa] = slot_of[pb];
    slot_of[pb] = t;
    t = pos_at_slot[sa];
    pos_at_slot[sa] = pos_at_slot[sb];
    pos_at_slot[sb] = t;
  endtask

  task automatic shift_bucket(int unsigned p, int unsigned from, int unsigned to);
    int unsigned prev, c, cur;
    prev = slot_of[clip(p)];
    c = from & 7;
    to = to & 7;
    if (c > to) begin
      while (c > to) begin
        cur = bstart[c];
        swap_slots(prev, cur);
        prev = cur;
        bstart[c]++;
        c--;
      end
    end else begin
      while (c < to) begin
        c++;
        bstart[c]--;
        cur = bstart[c];
        swap_slots(prev, cur);
        prev = cur;
      end
    end
  endtask

  task automatic flip_bit(int unsigned p, int unsigned c);
    int unsigned cl, cr;
    shift_bucket(p, c, c ^ 2);
    if (p - 1 > 0) begin
      cl = bucket_of(p - 1);
      shift_bucket(p - 1, cl, cl ^ 1);
    end
    if (p + 1 < seq_len - 1) begin
      cr = bucket_of(p + 1);
      shift_bucket(p + 1, cr, cr ^ 4);
    end
    flips_seen++;
  endtask

  task automatic predict_answer(output answer_t a);
    int unsigned pos, c, rk, size, rp;
    logic dropped;
    a = '0;
    pos = in_position;
    c = in_context_req;
    rk = in_rank;
    if (in_req_type == tcbe_pkg::REQ_LOAD) begin
      dropped = 1'b0;
      if (ready) begin
        ready = 1'b0;
        seq_len = 0;
      end
      if (seq_len < tcbe_pkg::MAX_LEN) begin
        seq_bits[seq_len] = in_bit_value;
        seq_len++;
      end else begin
        dropped = 1'b1;
        a.status = tcbe_pkg::ST_NOT_READY;
      end
      if (in_last) begin
        if (dropped || seq_len < 3) begin
          a.status = tcbe_pkg::ST_NOT_READY;
          seq_len = 0;
        end else begin
          sort_buckets();
          builds_seen++;
          a.status = tcbe_pkg::ST_OK;
        end
      end
    end else if (in_req_type <= tcbe_pkg::REQ_READ && !ready) begin
      a.status = tcbe_pkg::ST_NOT_READY;
    end else if (in_req_type == tcbe_pkg::REQ_FLIP_POS) begin
      if (pos < 1 || pos + 1 >= seq_len) begin
        a.status = tcbe_pkg::ST_BAD_POS;
      end else begin
        a.rctx = 3'(bucket_of(pos));
        a.rpos = 10'(pos);
        flip_bit(pos, a.rctx);
      end
    end else if (in_req_type == tcbe_pkg::REQ_FLIP_RANK) begin
      size = bstart[c+1] - bstart[c];
      if (rk >= size) begin
        a.status = tcbe_pkg::ST_BAD_RANK;
      end else begin
        rp = pos_at_slot[clip(bstart[c] + rk)];
        a.rpos = 10'(rp);
        a.rctx = 3'(c);
        flip_bit(rp, c);
      end
    end else if (in_req_type == tcbe_pkg::REQ_COUNT) begin
      a.cnt = 10'(bstart[c+1] - bstart[c]);
    end else if (in_req_type == tcbe_pkg::REQ_READ) begin
      if (pos >= seq_len) a.status = tcbe_pkg::ST_BAD_POS;
      else if (pos == 0) a.rbit = end_lo;
      else if (pos == seq_len - 1) a.rbit = end_hi;
      else a.rbit = 1'(bucket_of(pos) >> 1);
    end
  endtask

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst_n) begin
      answer_q.delete();
      for (int k = 0; k <= tcbe_pkg::NPAT; k++) bstart[k] = 0;
      end_lo = 1'b0;
      end_hi = 1'b0;
      seq_len = 0;
      ready = 1'b0;
      fail_count <= 0;
      answers_seen <= 0;
      flips_seen = 0;
      builds_seen = 0;
    end else begin
      if (out_valid) begin
        answers_seen <= answers_seen + 1;
        got = '{out_status, out_result_position, out_result_context, out_count,
                out_read_bit};
        if (answer_q.size() == 0) begin
          $error("answer with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (got != want) begin
            if (got.status != want.status)
              $error("status: expected %0d, got %0d", want.status, got.status);
            if (got.rpos != want.rpos)
              $error("result_position: expected %0d, got %0d", want.rpos, got.rpos);
            if (got.rctx != want.rctx)
              $error("result_context: expected %0d, got %0d", want.rctx, got.rctx);
            if (got.cnt != want.cnt)
              $error("count: expected %0d, got %0d", want.cnt, got.cnt);
            if (got.rbit != want.rbit)
              $error("read_bit: expected %0d, got %0d", want.rbit, got.rbit);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        predict_answer(want);
        answer_q.insert(answer_q.size(), want);
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// top of the bucket engine testbench: clock, reset, request stimulus and verdict
// depends on tcbe_pkg, triplet_context_bucket_engine_top and tcbe_checker

module tb_top;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_req_type;
  logic       in_bit_value;
  logic       in_last;
  logic [9:0] in_position;
  logic [2:0] in_context_req;
  logic [9:0] in_rank;
  logic       out_valid;
  logic [1:0] out_status;
  logic [9:0] out_result_position;
  logic [2:0] out_result_context;
  logic [9:0] out_count;
  logic       out_read_bit;

  int fail_count, pending, answers_seen, flips_seen, builds_seen;
  int cycles;
  int requests;
  int seq_n;
  bit no_gaps;

  triplet_context_bucket_engine_top u_dut (.*);

  tcbe_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] rq, logic b, logic lst, logic [9:0] p, logic [2:0] c,
                      logic [9:0] rk);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= rq;
    in_bit_value   <= b;
    in_last        <= lst;
    in_position    <= p;
    in_context_req <= c;
    in_rank        <= rk;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests++;
  endtask

  task automatic junk_load(logic b, logic lst);
    send(tcbe_pkg::REQ_LOAD, b, lst, 10'($urandom), 3'($urandom), 10'($urandom));
  endtask

  task automatic load_seq(int n, bit all_ones);
    for (int i = 0; i < n; i++)
      junk_load(all_ones ? 1'b1 : 1'($urandom), i == n - 1);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_op(int n);
    int pick;
    logic [9:0] p, rk;
    pick = $urandom_range(0, 99);
    p  = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                     : 10'($urandom_range(0, (n < 1023) ? n : 1023));
    rk = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, n / 4 + 2));
    if (pick < 30)
      send(tcbe_pkg::REQ_FLIP_POS, 1'($urandom), 1'($urandom), p, 3'($urandom), rk);
    else if (pick < 62)
      send(tcbe_pkg::REQ_FLIP_RANK, 1'($urandom), 1'($urandom), p, 3'($urandom), rk);
    else if (pick < 77)
      send(tcbe_pkg::REQ_COUNT, 1'($urandom), 1'($urandom), p, 3'($urandom), rk);
    else if (pick < 97)
      send(tcbe_pkg::REQ_READ, 1'($urandom), 1'($urandom), p, 3'($urandom), rk);
    else
      send(3'($urandom_range(5, 7)), 1'($urandom), 1'($urandom), p, 3'($urandom), rk);
  endtask

  initial begin
    start = 1'b0;
    in_req_type = tcbe_pkg::REQ_LOAD;
    in_bit_value = 1'b0;
    in_last = 1'b0;
    in_position = '0;
    in_context_req = '0;
    in_rank = '0;
    requests = 0;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // requests before any build, and unused codes
    send(tcbe_pkg::REQ_FLIP_POS, 1'b0, 1'b0, 10'd1, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_FLIP_RANK, 1'b0, 1'b0, 10'd0, 3'd7, 10'd0);
    send(tcbe_pkg::REQ_COUNT, 1'b0, 1'b0, 10'd0, 3'd2, 10'd0);
    send(tcbe_pkg::REQ_READ, 1'b0, 1'b0, 10'd0, 3'd0, 10'd0);
    for (int u = 5; u < 8; u++) send(3'(u), 1'b1, 1'b1, 10'h3ff, 3'd7, 10'h3ff);
    // too short
    load_seq(1, 1'b0);
    load_seq(2, 1'b1);
    // three bits: only position 1 is interior, both neighbours are ends
    load_seq(3, 1'b1);
    send(tcbe_pkg::REQ_FLIP_POS, 1'b0, 1'b0, 10'd1, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_READ, 1'b0, 1'b0, 10'd1, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_READ, 1'b0, 1'b0, 10'd2, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_READ, 1'b0, 1'b0, 10'd3, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_FLIP_POS, 1'b0, 1'b0, 10'd0, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_FLIP_POS, 1'b0, 1'b0, 10'd2, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_FLIP_RANK, 1'b0, 1'b0, 10'd0, 3'd5, 10'd0);
    send(tcbe_pkg::REQ_FLIP_RANK, 1'b0, 1'b0, 10'd0, 3'd5, 10'h3ff);
    for (int c = 0; c < 8; c++) send(tcbe_pkg::REQ_COUNT, 1'b0, 1'b0, 10'd0, 3'(c), 10'd0);
    drain();

    // full length held, then overflow with and without the last mark
    no_gaps = 1'b1;
    for (int i = 0; i < tcbe_pkg::MAX_LEN; i++) junk_load(1'($urandom), 1'b0);
    no_gaps = 1'b0;
    junk_load(1'b1, 1'b0);
    junk_load(1'b1, 1'b1);
    send(tcbe_pkg::REQ_COUNT, 1'b0, 1'b0, 10'd0, 3'd0, 10'd0);
    send(tcbe_pkg::REQ_READ, 1'b0, 1'b0, 10'd0, 3'd0, 10'd0);
    drain();

    // random sequences with bursts of operations
    seq_n = 0;
    while (requests < 1200) begin
      int n, ops;
      seq_n++;
      no_gaps = ($urandom_range(0, 3) == 0);
      if (seq_n % 3 == 0) drain();
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 120) : $urandom_range(3, 20);
      if ($urandom_range(0, 3) == 0) begin
        load_seq($urandom_range(1, 4), 1'b0);
        junk_load(1'($urandom), 1'b0);
      end
      load_seq(n, 1'b0);
      ops = $urandom_range(10, 30);
      for (int k = 0; k < ops; k++) begin
        if (k == ops / 2) no_gaps = ~no_gaps;
        random_op(n);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d requests over %0d random sequences: %0d builds, %0d flips",
             requests, seq_n, builds_seen, flips_seen);
    $display("%0d answers checked, %0d mismatching", answers_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tcbe_pkg.sv
src/tcbe_ram.sv
src/triplet_context_bucket_engine_top.sv
tb/tcbe_checker.sv
tb/tb_top.sv
